/* src/bamem_pkg.sv */
// Shared types and constants for the byte-addressed load/store memory.
package bamem_pkg;

  localparam int MEM_BYTES_DEF   = 16384;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [2:0] OP_LB  = 3'd0;
  localparam logic [2:0] OP_LBU = 3'd1;
  localparam logic [2:0] OP_LW  = 3'd2;
  localparam logic [2:0] OP_SB  = 3'd3;
  localparam logic [2:0] OP_SW  = 3'd4;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_MISALIGNED = 2'd1;
  localparam logic [1:0] ST_RANGE      = 2'd2;

  typedef enum logic [2:0] {
    ACT_LB  = 3'd0,
    ACT_LBU = 3'd1,
    ACT_LW  = 3'd2,
    ACT_SB  = 3'd3,
    ACT_SW  = 3'd4,
    ACT_NOP = 3'd5,
    ACT_REJ = 3'd6
  } act_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [31:0]        base_value;
    logic signed [11:0] offset_value;
    logic [31:0]        store_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    act_t        act;
    logic [1:0]  status;
    logic [31:0] addr;
    logic [31:0] data;
  } entry_t;

endpackage

/* src/bamem_front.sv */
// Front end: effective address, alignment and range checks, access classification.
module bamem_front import bamem_pkg::*; #(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input  in_item_t request,
  output entry_t   entry
);

  localparam logic [31:0] LAST_BYTE = 32'(MEM_BYTES - 1);
  localparam logic [31:0] LAST_WORD = 32'(MEM_BYTES - 4);

  logic [31:0] addr;
  logic        is_word;
  logic        is_load;
  logic        valid_op;

  assign addr     = request.base_value + {{20{request.offset_value[11]}},
                                          request.offset_value};
  assign is_word  = (request.opcode == OP_LW) || (request.opcode == OP_SW);
  assign is_load  = request.opcode inside {OP_LB, OP_LBU, OP_LW};
  assign valid_op = request.opcode inside {OP_LB, OP_LBU, OP_LW, OP_SB, OP_SW};

  always_comb begin
    entry.addr   = addr;
    entry.data   = request.store_data;
    entry.status = ST_OK;
    entry.act    = ACT_NOP;
    if (!valid_op) begin
      entry.act = ACT_NOP;
    end else if (is_word && (addr[1:0] != 2'd0)) begin
      entry.status = ST_MISALIGNED;
    end else if (is_word ? (addr > LAST_WORD) : (addr > LAST_BYTE)) begin
      entry.status = ST_RANGE;
    end else begin
      case (request.opcode)
        OP_LB:   entry.act = ACT_LB;
        OP_LBU:  entry.act = ACT_LBU;
        OP_LW:   entry.act = ACT_LW;
        OP_SB:   entry.act = ACT_SB;
        OP_SW:   entry.act = ACT_SW;
        default: entry.act = ACT_NOP;
      endcase
    end
    if (valid_op && (entry.status != ST_OK)) begin
      entry.act = is_load ? ACT_REJ : ACT_NOP;
    end
  end

endmodule

/* src/bamem_queue.sv */
// Small FIFO between front end and back end.
module bamem_queue import bamem_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wr_entry,
  input  logic   pop,
  output entry_t rd_entry,
  output logic   full,
  output logic   empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

/* src/bamem_back.sv */
// Back end: four byte-lane memory banks, load formatting and result register.
module bamem_back import bamem_pkg::*; #(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  entry_t    entry,
  output logic      done,
  output out_item_t result
);

  localparam int WORDS = (MEM_BYTES + 3) / 4;
  localparam int IW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [7:0]    bank [4][WORDS];
  logic [7:0]    rd_byte [4];
  logic [IW-1:0] idx;
  logic [1:0]    lane;
  logic [3:0]    we;

  logic          valid_s1;
  act_t          act_s1;
  logic [1:0]    status_s1;
  logic [1:0]    lane_s1;
  logic [7:0]    sel_byte;
  logic [31:0]   rdata;

  assign idx  = entry.addr[2 +: IW];
  assign lane = entry.addr[1:0];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      we[l] = in_valid && ((entry.act == ACT_SW) ||
                           ((entry.act == ACT_SB) && (lane == 2'(l))));
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      if (we[l]) begin
        bank[l][idx] <= (entry.act == ACT_SW) ? entry.data[8*l +: 8] : entry.data[7:0];
      end
      rd_byte[l] <= bank[l][idx];
    end
  end

  always_ff @(posedge clk) begin
    act_s1    <= entry.act;
    status_s1 <= entry.status;
    lane_s1   <= lane;
  end

  assign sel_byte = rd_byte[lane_s1];

  always_comb begin
    case (act_s1)
      ACT_LB:  rdata = {{24{sel_byte[7]}}, sel_byte};
      ACT_LBU: rdata = {24'd0, sel_byte};
      ACT_LW:  rdata = {rd_byte[3], rd_byte[2], rd_byte[1], rd_byte[0]};
      ACT_REJ: rdata = '1;
      default: rdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    result.read_data <= rdata;
    result.status    <= status_s1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s1 <= 1'b0;
      done     <= 1'b0;
    end else begin
      valid_s1 <= in_valid;
      done     <= valid_s1;
    end
  end

endmodule

/* src/byte_addressed_load_store_memory_top.sv */
// Top level: byte-addressed little-endian data memory with load/store beats.
// A beat accepted into the queue passes the bank read register and then the
// result format register before its result is strobed on done.
// Throughput: one beat per cycle; the back end drains the queue every cycle.
// Reset clears the queue and pipeline valid bits; memory contents are kept.
// The receiver cannot stall: each result is on result for one cycle only.
module byte_addressed_load_store_memory_top import bamem_pkg::*; #(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_item_t  request,
  output logic      done,
  output out_item_t result
);

  entry_t front_entry;
  entry_t back_entry;
  logic   q_full;
  logic   q_empty;

  bamem_front #(.MEM_BYTES(MEM_BYTES)) u_front (
    .request (request),
    .entry   (front_entry)
  );

  bamem_queue #(.DEPTH(QUEUE_DEPTH_DEF)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (start),
    .wr_entry (front_entry),
    .pop      (!q_empty),
    .rd_entry (back_entry),
    .full     (q_full),
    .empty    (q_empty)
  );

  bamem_back #(.MEM_BYTES(MEM_BYTES)) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (!q_empty),
    .entry    (back_entry),
    .done     (done),
    .result   (result)
  );

  assign busy = q_full;

endmodule
